/* src/pms_pkg.sv */
`default_nettype none

package pms_pkg;

  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned DELAY_BITS    = 13;

  localparam int unsigned REQ_BITS      = 2;
  localparam int unsigned PUSH_BITS     = 8;
  localparam int unsigned MODE_BITS     = 3;
  localparam int unsigned PULSE_BITS    = 12;
  localparam int unsigned SPEED_BITS    = 8;
  localparam int unsigned MS_BITS       = 13;
  localparam int unsigned PENDING_BITS  = 16;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 13;
  localparam int unsigned CALC_BITS     = 14;

  localparam logic [63:0] DELAY_MAX = (64'd1 << DELAY_BITS) - 64'd1;

  localparam logic [MODE_BITS-1:0] MODE_INACTIVE = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_ENDSTOP  = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_RAMPING  = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_PUSHING  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_BRAKING  = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_DONE     = 3'd5;

  localparam logic [REQ_BITS-1:0] REQ_TICK      = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_PUSH      = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_CALIBRATE = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_PULSE    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PULSE    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_MS      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_MS    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BRAKE_MS     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CALIBRATE_MS = 3'd6;

  localparam logic [SPEED_BITS-1:0] SPEED_RST        = 8'd18;
  localparam logic [PULSE_BITS-1:0] MIN_PULSE_RST    = 12'd1000;
  localparam logic [PULSE_BITS-1:0] MAX_PULSE_RST    = 12'd2000;
  localparam logic [MS_BITS-1:0]    RAMP_MS_RST      = 13'd300;
  localparam logic [MS_BITS-1:0]    SETTLE_MS_RST    = 13'd30;
  localparam logic [MS_BITS-1:0]    BRAKE_MS_RST     = 13'd25;
  localparam logic [MS_BITS-1:0]    CALIBRATE_MS_RST = 13'd5000;

  localparam logic [CALC_BITS-1:0]  PULSE_BASE = 14'd1000;
  localparam logic [CALC_BITS-1:0]  SPEED_STEP = 14'd10;
  localparam logic [CALC_BITS-1:0]  PULSE_MAX  = 14'd4095;

  typedef struct packed {
    logic [SPEED_BITS-1:0] speed;
    logic [PULSE_BITS-1:0] min_pulse;
    logic [MS_BITS-1:0]    ramp_ms;
    logic [MS_BITS-1:0]    settle_ms;
    logic [MS_BITS-1:0]    brake_ms;
    logic [MS_BITS-1:0]    calibrate_ms;
  } cfg_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [PULSE_BITS-1:0] pulse;
    logic                  dir_a;
    logic                  dir_b;
    logic [COUNT_BITS-1:0] pending;
    logic [DELAY_BITS-1:0] delay;
  } state_t;

  // A delay that does not fit the countdown saturates at its maximum.
  function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [MS_BITS-1:0] ms);
    logic [63:0] wide;
    wide = 64'(ms);
    if (wide > DELAY_MAX) begin
      sat_delay = '1;
    end else begin
      sat_delay = wide[DELAY_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* src/pms_cfg_regs.sv */
`default_nettype none

module pms_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [pms_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire logic [pms_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output pms_pkg::cfg_t                            cfg_o
);
  import pms_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // The maximum pulse has no register: its reset value only sets the pulse width after
  // reset, so a write to its index has no effect.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed        <= SPEED_RST;
      cfg_q.min_pulse    <= MIN_PULSE_RST;
      cfg_q.ramp_ms      <= RAMP_MS_RST;
      cfg_q.settle_ms    <= SETTLE_MS_RST;
      cfg_q.brake_ms     <= BRAKE_MS_RST;
      cfg_q.calibrate_ms <= CALIBRATE_MS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SPEED:        cfg_q.speed        <= cfg_data_i[SPEED_BITS-1:0];
        CFG_MIN_PULSE:    cfg_q.min_pulse    <= cfg_data_i[PULSE_BITS-1:0];
        CFG_RAMP_MS:      cfg_q.ramp_ms      <= cfg_data_i[MS_BITS-1:0];
        CFG_SETTLE_MS:    cfg_q.settle_ms    <= cfg_data_i[MS_BITS-1:0];
        CFG_BRAKE_MS:     cfg_q.brake_ms     <= cfg_data_i[MS_BITS-1:0];
        CFG_CALIBRATE_MS: cfg_q.calibrate_ms <= cfg_data_i[MS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/pms_core.sv */
`default_nettype none

module pms_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            step_i,
  input  wire logic [pms_pkg::REQ_BITS-1:0]    req_type_i,
  input  wire logic [pms_pkg::PUSH_BITS-1:0]   push_count_i,
  input  wire logic                            switch_closed_i,
  input  pms_pkg::cfg_t                        cfg_i,
  output pms_pkg::state_t                      state_d_o
);
  import pms_pkg::*;

  state_t                state_q;
  state_t                state_d;
  logic [DELAY_BITS-1:0] delay_dec;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS:0]   cnt_sum;
  logic [CALC_BITS-1:0]  drive;
  logic [PULSE_BITS-1:0] drive_pulse;

  assign drive     = PULSE_BASE + CALC_BITS'(cfg_i.speed) * SPEED_STEP;
  assign drive_pulse = (drive > PULSE_MAX) ? '1 : drive[PULSE_BITS-1:0];
  assign delay_dec = state_q.delay - DELAY_BITS'(state_q.delay != '0);
  assign cnt_sum   = {1'b0, state_q.pending} + (COUNT_BITS + 1)'(push_count_i);
  assign state_d_o = state_d;

  always_comb begin
    state_d = state_q;
    cnt     = state_q.pending;
    case (req_type_i)
      REQ_TICK: begin
        state_d.delay = delay_dec;
        if (delay_dec == '0) begin
          unique case (state_q.mode)
            MODE_RAMPING: begin
              state_d.mode  = MODE_ENDSTOP;
              state_d.dir_a = 1'b1;
              state_d.dir_b = 1'b0;
              state_d.delay = sat_delay(cfg_i.settle_ms);
            end
            MODE_BRAKING: begin
              state_d.mode  = MODE_DONE;
              state_d.dir_a = 1'b0;
              state_d.dir_b = 1'b0;
            end
            MODE_ENDSTOP: begin
              if (!switch_closed_i) begin
                state_d.mode  = MODE_PUSHING;
                state_d.delay = sat_delay(cfg_i.settle_ms);
              end
            end
            MODE_PUSHING: begin
              if (switch_closed_i && (cnt != '0)) begin
                state_d.mode  = MODE_ENDSTOP;
                cnt           = cnt - COUNT_BITS'(1);
                state_d.delay = sat_delay(cfg_i.settle_ms);
              end
              state_d.pending = cnt;
              if (cnt == '0) begin
                state_d.mode  = MODE_BRAKING;
                state_d.dir_a = 1'b0;
                state_d.dir_b = 1'b1;
                state_d.delay = sat_delay(cfg_i.brake_ms);
                state_d.pulse = cfg_i.min_pulse;
              end
            end
            default: begin
            end
          endcase
        end
      end
      REQ_PUSH: begin
        if (state_q.pending == '0) begin
          state_d.pending = COUNT_BITS'(push_count_i);
          state_d.pulse   = drive_pulse;
          state_d.mode    = MODE_RAMPING;
          state_d.delay   = sat_delay(cfg_i.ramp_ms);
        end else if (cnt_sum[COUNT_BITS]) begin
          state_d.pending = '1;
        end else begin
          state_d.pending = cnt_sum[COUNT_BITS-1:0];
        end
      end
      REQ_CALIBRATE: begin
        state_d.pulse = cfg_i.min_pulse;
        state_d.delay = sat_delay(cfg_i.calibrate_ms);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= MODE_INACTIVE;
      state_q.pulse   <= MAX_PULSE_RST;
      state_q.dir_a   <= 1'b0;
      state_q.dir_b   <= 1'b0;
      state_q.pending <= '0;
      state_q.delay   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* src/pusher_motor_sequencer.sv */
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-----------------------------------------
// in       | input     | in_valid_i / in_ready_o    | req_type_i, push_count_i, switch_closed_i
// out      | output    | out_valid_o / out_ready_i  | mode_o, pulse_us_o, dir_a_o, dir_b_o,
//          |           |                            | pushes_pending_o, waiting_o
// cfg      | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A word passes an input register and then the state update into the result register;
// one word is taken per cycle while the output does not stall.
// Reset loads the register reset values and clears both stages; no clearing pass is needed.
// When the result register is full and out_ready_i is low, the input register holds and
// in_ready_o falls once it too is full; the configuration port never stalls.
`default_nettype none

module pusher_motor_sequencer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [pms_pkg::REQ_BITS-1:0]        req_type_i,
  input  wire logic [pms_pkg::PUSH_BITS-1:0]       push_count_i,
  input  wire logic                                switch_closed_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [pms_pkg::MODE_BITS-1:0]            mode_o,
  output logic [pms_pkg::PULSE_BITS-1:0]           pulse_us_o,
  output logic                                     dir_a_o,
  output logic                                     dir_b_o,
  output logic [pms_pkg::PENDING_BITS-1:0]         pushes_pending_o,
  output logic                                     waiting_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [pms_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire logic [pms_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import pms_pkg::*;

  cfg_t                                cfg;
  state_t                              state_d;
  logic                                in_valid_q;
  logic [REQ_BITS-1:0]                 req_type_q;
  logic [PUSH_BITS-1:0]                push_count_q;
  logic                                switch_closed_q;
  logic                                out_valid_q;
  logic [MODE_BITS-1:0]                mode_q;
  logic [PULSE_BITS-1:0]               pulse_q;
  logic                                dir_a_q;
  logic                                dir_b_q;
  logic [PENDING_BITS-1:0]             pending_q;
  logic                                waiting_q;
  logic                                advance;
  logic                                step;
  logic [COUNT_BITS+PENDING_BITS-1:0]  pending_ext;

  assign advance     = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign pending_ext = {{PENDING_BITS{1'b0}}, state_d.pending};

  pms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pms_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .req_type_i      (req_type_q),
    .push_count_i    (push_count_q),
    .switch_closed_i (switch_closed_q),
    .cfg_i           (cfg),
    .state_d_o       (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_type_q      <= req_type_i;
      push_count_q    <= push_count_i;
      switch_closed_q <= switch_closed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      mode_q    <= state_d.mode;
      pulse_q   <= state_d.pulse;
      dir_a_q   <= state_d.dir_a;
      dir_b_q   <= state_d.dir_b;
      pending_q <= pending_ext[PENDING_BITS-1:0];
      waiting_q <= (state_d.delay != '0);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mode_o           = mode_q;
  assign pulse_us_o       = pulse_q;
  assign dir_a_o          = dir_a_q;
  assign dir_b_o          = dir_b_q;
  assign pushes_pending_o = pending_q;
  assign waiting_o        = waiting_q;

endmodule

`default_nettype wire

/* tb/sv/pms_motor_checker.sv */
module pms_motor_checker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_ready_i,
  input  wire logic [pms_pkg::REQ_BITS-1:0]        req_type_i,
  input  wire logic [pms_pkg::PUSH_BITS-1:0]       push_count_i,
  input  wire logic                                switch_closed_i,
  input  wire logic                                out_valid_i,
  input  wire logic                                out_ready_i,
  input  wire logic [pms_pkg::MODE_BITS-1:0]       mode_i,
  input  wire logic [pms_pkg::PULSE_BITS-1:0]      pulse_us_i,
  input  wire logic                                dir_a_i,
  input  wire logic                                dir_b_i,
  input  wire logic [pms_pkg::PENDING_BITS-1:0]    pushes_pending_i,
  input  wire logic                                waiting_i,
  input  wire logic                                cfg_valid_i,
  input  wire logic                                cfg_ready_i,
  input  wire logic [pms_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire logic [pms_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output int                                       mismatches_o,
  output int                                       awaited_o
);

  import pms_pkg::*;

  localparam int unsigned COUNT_LIMIT = (1 << COUNT_BITS) - 1;

  typedef struct packed {
    logic [MODE_BITS-1:0]    mode;
    logic [PULSE_BITS-1:0]   pulse;
    logic                    dir_a;
    logic                    dir_b;
    logic [PENDING_BITS-1:0] pushes;
    logic                    waiting;
  } motor_word_t;

  cfg_t        regs;
  state_t      motor;
  motor_word_t expected_words[$];

  function automatic state_t advance_motor(input state_t s, input cfg_t c,
                                           input logic [REQ_BITS-1:0] kind,
                                           input logic [PUSH_BITS-1:0] count,
                                           input logic closed);
    state_t n;
    int unsigned drive;
    int unsigned sum;
    n = s;
    case (kind)
      REQ_TICK: begin
        if (n.delay != 0) n.delay = n.delay - 1'b1;
        if (n.delay == 0) begin
          case (n.mode)
            MODE_RAMPING: begin
              n.mode  = MODE_ENDSTOP;
              n.dir_a = 1'b1;
              n.dir_b = 1'b0;
              n.delay = c.settle_ms;
            end
            MODE_BRAKING: begin
              n.mode  = MODE_DONE;
              n.dir_a = 1'b0;
              n.dir_b = 1'b0;
            end
            MODE_ENDSTOP: begin
              if (!closed) begin
                n.mode  = MODE_PUSHING;
                n.delay = c.settle_ms;
              end
            end
            MODE_PUSHING: begin
              if (closed && n.pending != 0) begin
                n.mode    = MODE_ENDSTOP;
                n.pending = n.pending - 1'b1;
                n.delay   = c.settle_ms;
              end
              // Running out of pushes reverse-brakes the motor.
              if (n.pending == 0) begin
                n.mode  = MODE_BRAKING;
                n.dir_a = 1'b0;
                n.dir_b = 1'b1;
                n.delay = c.brake_ms;
                n.pulse = c.min_pulse;
              end
            end
            default: begin
            end
          endcase
        end
      end
      REQ_PUSH: begin
        if (n.pending == 0) begin
          drive     = PULSE_BASE + SPEED_STEP * c.speed;
          n.pending = count;
          n.pulse   = (drive > PULSE_MAX) ? PULSE_BITS'(PULSE_MAX) : PULSE_BITS'(drive);
          n.mode    = MODE_RAMPING;
          n.delay   = c.ramp_ms;
        end else begin
          sum       = n.pending + count;
          n.pending = (sum > COUNT_LIMIT) ? '1 : COUNT_BITS'(sum);
        end
      end
      REQ_CALIBRATE: begin
        n.pulse = c.min_pulse;
        n.delay = c.calibrate_ms;
      end
      default: begin
      end
    endcase
    return n;
  endfunction

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    motor_word_t want;
    if (!rst_ni) begin
      regs = '{speed: SPEED_RST, min_pulse: MIN_PULSE_RST, ramp_ms: RAMP_MS_RST,
               settle_ms: SETTLE_MS_RST, brake_ms: BRAKE_MS_RST,
               calibrate_ms: CALIBRATE_MS_RST};
      motor = '{mode: MODE_INACTIVE, pulse: MAX_PULSE_RST, dir_a: 1'b0, dir_b: 1'b0,
                pending: '0, delay: '0};
      expected_words.delete();
      mismatches_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result expected none, actual mode %0d pushes %0d", $time,
                   mode_i, pushes_pending_i);
          mismatches_o++;
        end else begin
          want = expected_words.pop_front();
          check_field("mode", want.mode, mode_i);
          check_field("pulse_us", want.pulse, pulse_us_i);
          check_field("dir_a", want.dir_a, dir_a_i);
          check_field("dir_b", want.dir_b, dir_b_i);
          check_field("pushes_pending", want.pushes, pushes_pending_i);
          check_field("waiting", want.waiting, waiting_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        // The maximum pulse only matters at reset, so later writes change nothing.
        case (cfg_index_i)
          CFG_SPEED:        regs.speed        = cfg_data_i[SPEED_BITS-1:0];
          CFG_MIN_PULSE:    regs.min_pulse    = cfg_data_i[PULSE_BITS-1:0];
          CFG_RAMP_MS:      regs.ramp_ms      = cfg_data_i;
          CFG_SETTLE_MS:    regs.settle_ms    = cfg_data_i;
          CFG_BRAKE_MS:     regs.brake_ms     = cfg_data_i;
          CFG_CALIBRATE_MS: regs.calibrate_ms = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        motor = advance_motor(motor, regs, req_type_i, push_count_i, switch_closed_i);
        expected_words.push_back('{mode: motor.mode, pulse: motor.pulse, dir_a: motor.dir_a,
                                   dir_b: motor.dir_b, pushes: motor.pending[PENDING_BITS-1:0],
                                   waiting: (motor.delay != 0)});
      end
    end
    awaited_o = expected_words.size();
  end

endmodule

/* tb/sv/tb_pusher_motor_sequencer.sv */
module tb_pusher_motor_sequencer;

  import pms_pkg::*;

  localparam logic [REQ_BITS-1:0]     REQ_RESERVED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED   = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [REQ_BITS-1:0]      req_type_i;
  logic [PUSH_BITS-1:0]     push_count_i;
  logic                     switch_closed_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [MODE_BITS-1:0]     mode_o;
  logic [PULSE_BITS-1:0]    pulse_us_o;
  logic                     dir_a_o;
  logic                     dir_b_o;
  logic [PENDING_BITS-1:0]  pushes_pending_o;
  logic                     waiting_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int          mismatch_count;
  int          awaited_count;
  int          idle_cycles;
  logic        switch_level;

  pusher_motor_sequencer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .push_count_i     (push_count_i),
    .switch_closed_i  (switch_closed_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mode_o           (mode_o),
    .pulse_us_o       (pulse_us_o),
    .dir_a_o          (dir_a_o),
    .dir_b_o          (dir_b_o),
    .pushes_pending_o (pushes_pending_o),
    .waiting_o        (waiting_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  pms_motor_checker watch (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .req_type_i       (req_type_i),
    .push_count_i     (push_count_i),
    .switch_closed_i  (switch_closed_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .mode_i           (mode_o),
    .pulse_us_i       (pulse_us_o),
    .dir_a_i          (dir_a_o),
    .dir_b_i          (dir_b_o),
    .pushes_pending_i (pushes_pending_o),
    .waiting_i        (waiting_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatches_o     (mismatch_count),
    .awaited_o        (awaited_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The valid line is only lowered when a gap starts or the stimulus pauses, so a
  // word that follows an accepted one keeps valid high without a glitch.
  task automatic send_word(input logic [REQ_BITS-1:0] kind, input logic [PUSH_BITS-1:0] count,
                           input logic closed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    push_count_i    <= count;
    switch_closed_i <= closed;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic random_word(input bit wide_counts);
    int unsigned pick;
    logic [PUSH_BITS-1:0] count;
    pick  = $urandom_range(0, 99);
    count = wide_counts ? PUSH_BITS'($urandom) : PUSH_BITS'($urandom_range(0, 3));
    if (pick < 78) begin
      if ($urandom_range(0, 99) < 60) switch_level = ~switch_level;
      send_word(REQ_TICK, PUSH_BITS'($urandom), switch_level);
    end else if (pick < 92) begin
      send_word(REQ_PUSH, count, 1'($urandom));
    end else if (pick < 96) begin
      send_word(REQ_CALIBRATE, PUSH_BITS'($urandom), 1'($urandom));
    end else begin
      send_word(REQ_RESERVED, PUSH_BITS'($urandom), 1'($urandom));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_settings(input int unsigned speed, input int unsigned min_pulse,
                               input int unsigned max_pulse, input int unsigned ramp,
                               input int unsigned settle, input int unsigned brake,
                               input int unsigned calibrate);
    write_reg(CFG_SPEED, CFG_DATA_BITS'(speed));
    write_reg(CFG_MIN_PULSE, CFG_DATA_BITS'(min_pulse));
    write_reg(CFG_MAX_PULSE, CFG_DATA_BITS'(max_pulse));
    write_reg(CFG_RAMP_MS, CFG_DATA_BITS'(ramp));
    write_reg(CFG_SETTLE_MS, CFG_DATA_BITS'(settle));
    write_reg(CFG_BRAKE_MS, CFG_DATA_BITS'(brake));
    write_reg(CFG_CALIBRATE_MS, CFG_DATA_BITS'(calibrate));
    write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_random_settings();
    load_settings($urandom_range(0, 255), $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4), $urandom_range(0, 3), $urandom_range(0, 3),
                  $urandom_range(0, 5));
  endtask

  task automatic set_idling(input idle_mode_e how);
    case (how)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 56;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = 56;
      end
      default: begin
        send_idle_pct = 6;
        stall_pct     = 6;
      end
    endcase
  endtask

  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    req_type_i      = REQ_TICK;
    push_count_i    = '0;
    switch_closed_i = 1'b0;
    out_ready_i     = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_SPEED;
    cfg_data_i      = '0;
    switch_level    = 1'b0;
    idle_cycles     = 0;
    set_idling(IDLE_NONE);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of the registers and the state.
    send_word(REQ_TICK, 8'h00, 1'b0);
    send_word(REQ_TICK, 8'hFF, 1'b1);
    send_word(REQ_RESERVED, 8'hFF, 1'b1);
    send_word(REQ_CALIBRATE, 8'h00, 1'b0);
    send_word(REQ_PUSH, 8'd1, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b0);
    settle_pipeline();

    load_settings(255, 4095, 4095, 0, 0, 0, 0);
    set_idling(IDLE_RECEIVER);
    send_word(REQ_CALIBRATE, 8'h00, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b1);
    send_word(REQ_TICK, 8'h00, 1'b1);
    send_word(REQ_TICK, 8'h00, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b1);
    send_word(REQ_TICK, 8'h00, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b0);
    // A push of zero with nothing pending still starts the motor.
    send_word(REQ_PUSH, 8'd0, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b0);
    send_word(REQ_PUSH, 8'd2, 1'b1);
    send_word(REQ_PUSH, 8'd3, 1'b0);
    send_word(REQ_PUSH, 8'd0, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b0);
    send_word(REQ_TICK, 8'h00, 1'b1);
    send_word(REQ_RESERVED, 8'h80, 1'b0);
    send_word(REQ_CALIBRATE, 8'h7F, 1'b1);
    send_word(REQ_TICK, 8'h00, 1'b0);

    for (phase = 0; phase < 5; phase++) begin
      settle_pipeline();
      if (phase == 1) begin
        load_settings(0, 0, 0, 8191, 8191, 8191, 8191);
      end else begin
        load_random_settings();
      end
      set_idling(idle_mode_e'(phase % 4));
      repeat ((phase == 1) ? 40 : 360) random_word(1'b0);
    end

    // Large counts last, since the pending count can only drain one push at a time.
    settle_pipeline();
    load_random_settings();
    set_idling(IDLE_SENDER);
    repeat (40) random_word(1'b1);
    repeat (262) send_word(REQ_PUSH, 8'hFF, 1'($urandom));
    repeat (20) random_word(1'b1);
    settle_pipeline();
    @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/pms_pkg.sv
src/pms_cfg_regs.sv
src/pms_core.sv
src/pusher_motor_sequencer.sv
tb/sv/pms_motor_checker.sv
tb/sv/tb_pusher_motor_sequencer.sv
